@@ hdl/uabm_pkg.sv @@
package uabm_pkg;

	localparam int VFIELD_W = 6;
	localparam int CMD_W = 3;
	localparam int TOTAL_W = 11;
	localparam int STATUS_W = 2;
	localparam int VCOUNT_W = 7;
	localparam int VERTEX_LIMIT = 2 ** VFIELD_W;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int VERTEX_COUNT_RESET = 64;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_CONNECT    = 3'd0,
		CMD_DISCONNECT = 3'd1,
		CMD_QUERY      = 3'd2,
		CMD_RESTART    = 3'd3,
		CMD_NEXT       = 3'd4
	} uabm_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SELF  = 2'd2
	} uabm_status_t;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [VFIELD_W-1:0] vertex_a;
		logic [VFIELD_W-1:0] vertex_b;
	} uabm_req_t;

	typedef struct packed {
		logic                connected;
		logic                changed;
		logic                edge_valid;
		logic [VFIELD_W-1:0] edge_low;
		logic [VFIELD_W-1:0] edge_high;
		logic [TOTAL_W-1:0]  edge_total;
		logic [STATUS_W-1:0] status;
	} uabm_res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_PAIR,
		S_SCAN
	} uabm_state_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_SIMPLE,
		OP_PAIR_READ,
		OP_PAIR_WRITE,
		OP_SCAN_START,
		OP_SCAN_STEP,
		OP_FOUND,
		OP_EXHAUSTED
	} uabm_op_t;

	typedef struct packed {
		logic pair_go;
		logic next_cmd;
		logic at_end;
		logic found;
		logic last_row;
	} uabm_flags_t;

endpackage

@@ hdl/undirected_adjacency_bit_matrix.sv @@
// Undirected graph store held as upper-triangular adjacency bits, one row word
// per vertex in a single-port-read row memory.
// Command channel: an item (command, vertex_a, vertex_b) is taken on a rising
// edge where start is high and busy is low. Commands are connect, disconnect,
// query, restart enumeration and next edge.
// Result channel: done is high for exactly one cycle with the result fields
// on result; the receiver has no way to hold it off, so it must take the
// transfer in that cycle.
// Sequence: a rejected command, a restart or an unused code is answered from
// decode after acceptance; connect, disconnect and query go on to a row read,
// then update and write-back. Next edge reads the cursor row, then one row
// word a cycle from the row memory until it finds an edge or passes the last
// row; a cursor already at the end is answered from decode. busy is low again
// in the cycle that done is raised, so a new command may follow.
// Configuration: the vertex count register sits at byte address 0 of the APB
// port. Writing it clears all edges, the edge total and the enumeration cursor
// through per-row valid bits; it must only be written while the block is idle.
// Reset: all edges cleared, cursor at the start, the vertex count back to 64.
module undirected_adjacency_bit_matrix import uabm_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  uabm_req_t         request,
	output logic              done,
	output uabm_res_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Register index taken from the word address bit.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	logic [VCOUNT_W-1:0] vcount_q;
	logic                cfg_write;
	uabm_flags_t         flags;
	uabm_op_t            op;

	// A vertex count write completes on the access cycle of the transfer.
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_W'(VERTEX_COUNT_RESET);
		end else if (cfg_write) begin
			vcount_q <= pwdata[VCOUNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DW'(vcount_q) : '0;

	// The controller sequences each command; the datapath holds the rows,
	// the cursor and the edge total.
	uabm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.busy   (busy),
		.op     (op)
	);

	uabm_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.request (request),
		.vcount  (vcount_q),
		.clear   (cfg_write),
		.flags   (flags),
		.done    (done),
		.result  (result)
	);

endmodule

@@ hdl/uabm_ram.sv @@
module uabm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/uabm_ctrl.sv @@
module uabm_ctrl import uabm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  uabm_flags_t flags,
	output logic        busy,
	output uabm_op_t    op
);

	uabm_state_t state_q;
	uabm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op = OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (flags.pair_go) begin
					op = OP_PAIR_READ;
					state_d = S_PAIR;
				end else if (flags.next_cmd && flags.at_end) begin
					op = OP_EXHAUSTED;
					state_d = S_IDLE;
				end else if (flags.next_cmd) begin
					op = OP_SCAN_START;
					state_d = S_SCAN;
				end else begin
					op = OP_SIMPLE;
					state_d = S_IDLE;
				end
			end
			S_PAIR: begin
				op = OP_PAIR_WRITE;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				priority if (flags.found) begin
					op = OP_FOUND;
					state_d = S_IDLE;
				end else if (flags.last_row) begin
					op = OP_EXHAUSTED;
					state_d = S_IDLE;
				end else begin
					op = OP_SCAN_STEP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ hdl/uabm_dp.sv @@
module uabm_dp import uabm_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  uabm_op_t            op,
	input  uabm_req_t           request,
	input  logic [VCOUNT_W-1:0] vcount,
	input  logic                clear,
	output uabm_flags_t         flags,
	output logic                done,
	output uabm_res_t           result
);

	localparam int ROWS = (MAX_VERTICES < VERTEX_LIMIT) ? MAX_VERTICES : VERTEX_LIMIT;
	localparam int ROW_IW = $clog2(ROWS);
	localparam int NW = $clog2(ROWS + 1);
	localparam int CW = $clog2(ROWS + 2);

	uabm_req_t          req_q;
	logic [TOTAL_W-1:0] edges_q;
	logic [NW-1:0]      cur_row_q;
	logic [CW-1:0]      cur_col_q;
	logic [ROW_IW-1:0]  chk_row_q;
	logic [NW-1:0]      rd_ptr_q;
	logic [CW-1:0]      lb_q;
	logic [ROWS-1:0]    row_valid_q;
	logic               rvalid_s1;
	logic               done_q;
	uabm_res_t          res_q;

	logic [NW-1:0]       n;
	logic [VCOUNT_W-1:0] n_ext;
	logic                pair_cmd;
	logic                range_bad;
	logic                self_loop;
	uabm_status_t        status_w;
	logic [VFIELD_W-1:0] pair_lo;
	logic [VFIELD_W-1:0] pair_hi;
	logic [ROW_IW-1:0]   pair_row;
	logic [ROW_IW-1:0]   pair_col;
	logic                ram_re;
	logic [ROW_IW-1:0]   ram_raddr;
	logic                ram_we;
	logic [ROWS-1:0]     ram_wdata;
	logic [ROWS-1:0]     ram_rdata;
	logic [ROWS-1:0]     row_w;
	logic [ROWS-1:0]     bit_vec;
	logic                old_bit;
	logic                set_bit;
	logic                clr_bit;
	logic [ROWS-1:0]     col_mask;
	logic [ROWS-1:0]     masked;
	logic [ROWS-1:0]     lowest;
	logic [ROW_IW-1:0]   hit_col;
	logic                res_load;
	uabm_res_t           res_d;

	assign n = (vcount > VCOUNT_W'(ROWS)) ? NW'(ROWS) : NW'(vcount);
	assign n_ext = VCOUNT_W'(n);

	assign pair_cmd = (req_q.command == CMD_CONNECT) || (req_q.command == CMD_DISCONNECT)
		|| (req_q.command == CMD_QUERY);
	assign range_bad = (VCOUNT_W'(req_q.vertex_a) >= n_ext) || (VCOUNT_W'(req_q.vertex_b) >= n_ext);
	assign self_loop = (req_q.vertex_a == req_q.vertex_b);

	always_comb begin
		status_w = ST_OK;
		if (pair_cmd && range_bad) begin
			status_w = ST_RANGE;
		end else if (pair_cmd && self_loop) begin
			status_w = ST_SELF;
		end
	end

	assign pair_lo = (req_q.vertex_a < req_q.vertex_b) ? req_q.vertex_a : req_q.vertex_b;
	assign pair_hi = (req_q.vertex_a < req_q.vertex_b) ? req_q.vertex_b : req_q.vertex_a;
	assign pair_row = ROW_IW'(pair_lo);
	assign pair_col = ROW_IW'(pair_hi);

	// A row never written since the last clear reads as all zero.
	assign row_w = ram_rdata & {ROWS{rvalid_s1}};
	assign bit_vec = ROWS'(1) << pair_col;
	assign old_bit = row_w[pair_col];
	assign set_bit = (req_q.command == CMD_CONNECT) && !old_bit;
	assign clr_bit = (req_q.command == CMD_DISCONNECT) && old_bit;
	assign ram_we = (op == OP_PAIR_WRITE) && (set_bit || clr_bit);
	assign ram_wdata = set_bit ? (row_w | bit_vec) : (row_w & ~bit_vec);

	always_comb begin
		ram_re = 1'b1;
		ram_raddr = pair_row;
		unique case (op)
			OP_PAIR_READ:  ram_raddr = pair_row;
			OP_SCAN_START: ram_raddr = cur_row_q[ROW_IW-1:0];
			OP_SCAN_STEP:  ram_raddr = rd_ptr_q[ROW_IW-1:0];
			default:       ram_re = 1'b0;
		endcase
	end

	uabm_ram #(
		.WIDTH(ROWS),
		.DEPTH(ROWS)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pair_row),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Search of one row: columns from the lower bound up to but not including n, lowest set bit wins.
	always_comb begin
		for (int j = 0; j < ROWS; j++) begin
			col_mask[j] = (CW'(j) >= lb_q) && (NW'(j) < n);
		end
	end

	assign masked = row_w & col_mask;
	assign lowest = masked & (~masked + ROWS'(1));

	always_comb begin
		hit_col = '0;
		for (int j = 0; j < ROWS; j++) begin
			if (lowest[j]) begin
				hit_col = hit_col | ROW_IW'(j);
			end
		end
	end

	assign flags.pair_go = pair_cmd && !range_bad && !self_loop;
	assign flags.next_cmd = (req_q.command == CMD_NEXT);
	assign flags.at_end = (cur_row_q >= n);
	assign flags.found = |masked;
	assign flags.last_row = ((NW'(chk_row_q) + NW'(1)) >= n);

	assign res_load = (op == OP_SIMPLE) || (op == OP_PAIR_WRITE) || (op == OP_FOUND)
		|| (op == OP_EXHAUSTED);

	// The result word for the command that finishes in this cycle.
	always_comb begin
		res_d = '0;
		res_d.edge_total = edges_q;
		res_d.status = ST_OK;
		unique case (op)
			OP_SIMPLE: begin
				res_d.status = status_w;
			end
			OP_PAIR_WRITE: begin
				res_d.connected = old_bit;
				res_d.changed = set_bit || clr_bit;
				res_d.edge_total = set_bit ? edges_q + TOTAL_W'(1)
					: (clr_bit ? edges_q - TOTAL_W'(1) : edges_q);
			end
			OP_FOUND: begin
				res_d.edge_valid = 1'b1;
				res_d.edge_low = VFIELD_W'(chk_row_q);
				res_d.edge_high = VFIELD_W'(hit_col);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q <= '0;
			cur_row_q <= '0;
			cur_col_q <= CW'(1);
			row_valid_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= res_load;
			if (clear) begin
				edges_q <= '0;
				cur_row_q <= '0;
				cur_col_q <= CW'(1);
				row_valid_q <= '0;
			end else begin
				unique case (op)
					OP_SIMPLE: begin
						if (req_q.command == CMD_RESTART) begin
							cur_row_q <= '0;
							cur_col_q <= CW'(1);
						end
					end
					OP_PAIR_WRITE: begin
						if (set_bit) begin
							edges_q <= edges_q + TOTAL_W'(1);
						end else if (clr_bit) begin
							edges_q <= edges_q - TOTAL_W'(1);
						end
						if (ram_we) begin
							row_valid_q[pair_row] <= 1'b1;
						end
					end
					OP_FOUND: begin
						cur_row_q <= NW'(chk_row_q);
						cur_col_q <= CW'(hit_col) + CW'(1);
					end
					OP_EXHAUSTED: begin
						cur_row_q <= n;
						cur_col_q <= CW'(n) + CW'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			req_q <= request;
		end
		if (ram_re) begin
			rvalid_s1 <= row_valid_q[ram_raddr];
		end
		if (op == OP_SCAN_START) begin
			chk_row_q <= cur_row_q[ROW_IW-1:0];
			rd_ptr_q <= cur_row_q + NW'(1);
			lb_q <= cur_col_q;
		end else if (op == OP_SCAN_STEP) begin
			chk_row_q <= rd_ptr_q[ROW_IW-1:0];
			rd_ptr_q <= rd_ptr_q + NW'(1);
			lb_q <= CW'(rd_ptr_q) + CW'(1);
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

@@ hdl/uabm_checker.sv @@
module uabm_checker import uabm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input uabm_res_t result
);

	// An accepted command always occupies the block for the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted command");

	// Results never arrive on consecutive cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results on consecutive cycles");

	// An enumerated edge is ordered and carries no pair outcome.
	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.edge_valid |->
			(result.edge_low < result.edge_high) && !result.changed && !result.connected
			&& (result.status == ST_OK))
		else $error("malformed enumerated edge");

	// A rejected pair never reports or alters a connection.
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |->
			!result.changed && !result.connected && !result.edge_valid)
		else $error("rejected command reported a connection");

endmodule

bind undirected_adjacency_bit_matrix uabm_checker u_uabm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import uabm_pkg::*;

	// The enumeration search can walk every row once, so the settle wait
	// below grows with the vertex cap.
	localparam int VERTEX_CAP = (MAX_VERTICES_DEF < VERTEX_LIMIT) ?
		MAX_VERTICES_DEF : VERTEX_LIMIT;
	localparam int SETTLE_CYCLES = VERTEX_CAP + 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOT_VERTICES = 12;

	// Command codes that the block does not decode and simply answers.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// Byte address of the vertex count register on the APB port.
	localparam logic [APB_AW-1:0] VCOUNT_ADDR = '0;

	// Clock and reset. Every input of the block starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic start = 1'b0;
	logic busy;
	uabm_req_t request = '0;
	logic done;
	uabm_res_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	always #1 clk = ~clk;

	undirected_adjacency_bit_matrix dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Commands waiting to be offered, and the answers predicted for the
	// commands the block has already taken, oldest first.
	uabm_req_t command_queue[$];
	uabm_res_t awaited_answers[$];

	int unsigned failures = 0;
	int unsigned idle_left = 0;
	int unsigned stall_cycles = 0;
	bit pauses_allowed = 1'b1;

	// Our own copy of the graph: row i holds at bit j the link (i, j), i < j.
	logic [VERTEX_LIMIT-1:0] graph_rows [VERTEX_LIMIT];
	int scan_row;
	int scan_col;
	logic [TOTAL_W-1:0] link_count;
	logic [VCOUNT_W-1:0] vcount_setting;

	// Both reset and a write of the vertex count empty the graph and send
	// the enumeration cursor back to its first position.
	function automatic void clear_graph();
		foreach (graph_rows[i])
			graph_rows[i] = '0;
		link_count = '0;
		scan_row = 0;
		scan_col = 1;
	endfunction

	function automatic int usable_vertices();
		return (int'(vcount_setting) > VERTEX_CAP) ? VERTEX_CAP : int'(vcount_setting);
	endfunction

	// Works out the answer to one command and updates the graph copy, in the
	// same order as the block: range check, then self-loop check, then the
	// command itself.
	function automatic uabm_res_t apply_command(uabm_req_t req);
		uabm_res_t res;
		int n;
		int a;
		int b;
		int lo;
		int hi;
		int r;
		int c;
		bit found;

		res = '0;
		res.status = ST_OK;
		n = usable_vertices();
		a = int'(req.vertex_a);
		b = int'(req.vertex_b);
		found = 1'b0;
		if (req.command == CMD_CONNECT || req.command == CMD_DISCONNECT ||
				req.command == CMD_QUERY) begin
			if (a >= n || b >= n) begin
				res.status = ST_RANGE;
			end else if (a == b) begin
				res.status = ST_SELF;
			end else begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
				res.connected = graph_rows[lo][hi];
				if (req.command == CMD_CONNECT && !graph_rows[lo][hi]) begin
					graph_rows[lo][hi] = 1'b1;
					link_count = link_count + 1'b1;
					res.changed = 1'b1;
				end else if (req.command == CMD_DISCONNECT && graph_rows[lo][hi]) begin
					graph_rows[lo][hi] = 1'b0;
					link_count = link_count - 1'b1;
					res.changed = 1'b1;
				end
			end
		end else if (req.command == CMD_RESTART) begin
			scan_row = 0;
			scan_col = 1;
		end else if (req.command == CMD_NEXT) begin
			// Row-major search from the cursor; links added behind it are
			// only found after a restart.
			r = scan_row;
			c = scan_col;
			while (r < n && !found) begin
				if (c <= r)
					c = r + 1;
				while (c < n && !found) begin
					if (graph_rows[r][c])
						found = 1'b1;
					else
						c++;
				end
				if (!found) begin
					r++;
					c = r + 1;
				end
			end
			if (found) begin
				res.edge_valid = 1'b1;
				res.edge_low = r[VFIELD_W-1:0];
				res.edge_high = c[VFIELD_W-1:0];
				scan_row = r;
				scan_col = c + 1;
			end else begin
				// Once the links are used up the cursor parks past the last row.
				scan_row = n;
				scan_col = n + 1;
			end
		end
		res.edge_total = link_count;
		return res;
	endfunction

	function automatic uabm_req_t make_request(logic [CMD_W-1:0] cmd, int a, int b);
		uabm_req_t req;

		req.command = cmd;
		req.vertex_a = a[VFIELD_W-1:0];
		req.vertex_b = b[VFIELD_W-1:0];
		return req;
	endfunction

	// Picks two distinct vertices, mostly from a small set of low numbers so
	// that links get hit again by connect, disconnect and query.
	task automatic pick_pair(input int n, output int a, output int b);
		int hot;

		if (n < 2) begin
			a = $urandom_range(VERTEX_LIMIT - 1, 0);
			b = $urandom_range(VERTEX_LIMIT - 1, 0);
		end else begin
			hot = (n < HOT_VERTICES) ? n : HOT_VERTICES;
			a = ($urandom_range(9, 0) < 7) ? $urandom_range(hot - 1, 0) :
				$urandom_range(n - 1, 0);
			do
				b = ($urandom_range(9, 0) < 7) ? $urandom_range(hot - 1, 0) :
					$urandom_range(n - 1, 0);
			while (b == a);
		end
	endtask

	// Random commands for the current vertex count. Most are well-formed
	// pair commands and enumeration runs; the rest is rejected or ignored
	// noise.
	task automatic queue_random_commands(input int count);
		int n;
		int added;
		int pick;
		int a;
		int b;
		int run;
		logic [CMD_W-1:0] cmd;

		n = usable_vertices();
		added = 0;
		while (added < count) begin
			pick = $urandom_range(99, 0);
			if (pick < 10) begin
				// A restart followed by a run of next-edge commands.
				run = $urandom_range(8, 1);
				command_queue.push_back(make_request(CMD_RESTART,
					$urandom_range(VERTEX_LIMIT - 1, 0), $urandom_range(VERTEX_LIMIT - 1, 0)));
				repeat (run)
					command_queue.push_back(make_request(CMD_NEXT,
						$urandom_range(VERTEX_LIMIT - 1, 0), $urandom_range(VERTEX_LIMIT - 1, 0)));
				added += run + 1;
			end else begin
				a = $urandom_range(VERTEX_LIMIT - 1, 0);
				b = $urandom_range(VERTEX_LIMIT - 1, 0);
				if (pick < 45) begin
					cmd = CMD_CONNECT;
					pick_pair(n, a, b);
				end else if (pick < 58) begin
					cmd = CMD_DISCONNECT;
					pick_pair(n, a, b);
				end else if (pick < 70) begin
					cmd = CMD_QUERY;
					pick_pair(n, a, b);
				end else if (pick < 78) begin
					cmd = CMD_NEXT;
				end else if (pick < 82) begin
					cmd = CMD_RESTART;
				end else if (pick < 88) begin
					// Self loop on a pair command.
					cmd = CMD_W'($urandom_range(CMD_QUERY, CMD_CONNECT));
					if (n > 0)
						a = $urandom_range(n - 1, 0);
					b = a;
				end else if (pick < 93) begin
					// At least one endpoint beyond the vertices in use, on either side.
					cmd = CMD_W'($urandom_range(CMD_QUERY, CMD_CONNECT));
					if (n < VERTEX_LIMIT) begin
						a = $urandom_range(VERTEX_LIMIT - 1, n);
						if ($urandom_range(1, 0) == 1) begin
							run = a;
							a = b;
							b = run;
						end
					end
				end else if (pick < 96) begin
					cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
				end else begin
					cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_CONNECT));
				end
				command_queue.push_back(make_request(cmd, a, b));
				added++;
			end
		end
	endtask

	// Waits until every command has been taken and every answer has come.
	// The check is made at the falling edge, when all updates have settled.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (command_queue.size() != 0 || start || awaited_answers.size() != 0);
	endtask

	// APB write of the vertex count, then a read back of the same register.
	// Only called while the block is idle.
	task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= VCOUNT_ADDR;
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		// The register took the value at this edge, and the graph is empty.
		vcount_setting = value;
		clear_graph();
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[VCOUNT_W-1:0] !== value) begin
			$error("vertex count: expected %0d, got %0d", value, prdata[VCOUNT_W-1:0]);
			failures++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			failures++;
		end
	endtask

	// Driver. A command is taken at an edge where start is high and busy is
	// low; the answer is predicted right there, at the transfer. Between
	// commands the driver may insert a random idle burst while pauses are allowed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
			idle_left <= 0;
		end else begin
			if (start && !busy)
				awaited_answers.push_back(apply_command(request));
			if (start && busy) begin
				// The block has not taken the command yet, so it is held.
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (command_queue.size() != 0 && pauses_allowed &&
					$urandom_range(9, 0) == 0) begin
				start <= 1'b0;
				idle_left <= $urandom_range(5, 0);
			end else if (command_queue.size() != 0) begin
				start <= 1'b1;
				request <= command_queue.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. A result is valid for the single cycle in which done is high
	// and is compared with the oldest predicted answer, field by field.
	always @(posedge clk) begin
		uabm_res_t want;

		if (arst_n && done) begin
			if (awaited_answers.size() == 0) begin
				$error("result transfer with no answer awaited");
				failures++;
			end else begin
				want = awaited_answers.pop_front();
				check_field("connected", int'(want.connected), int'(result.connected));
				check_field("changed", int'(want.changed), int'(result.changed));
				check_field("edge_valid", int'(want.edge_valid), int'(result.edge_valid));
				check_field("edge_low", int'(want.edge_low), int'(result.edge_low));
				check_field("edge_high", int'(want.edge_high), int'(result.edge_high));
				check_field("edge_total", int'(want.edge_total), int'(result.edge_total));
				check_field("status", int'(want.status), int'(result.status));
			end
		end
	end

	// Watchdog. Any transfer on any port restarts the count; a long run of
	// cycles without one means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable)) begin
				stall_cycles <= 0;
			end else if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("testbench failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		vcount_setting = VCOUNT_W'(VERTEX_COUNT_RESET);
		clear_graph();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed commands on the full vertex range after reset. Next edge on
		// an empty graph runs the cursor off the end, so a restart follows.
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		command_queue.push_back(make_request(CMD_RESTART, 0, 0));
		command_queue.push_back(make_request(CMD_CONNECT, 0, 63));
		command_queue.push_back(make_request(CMD_CONNECT, 63, 0));
		command_queue.push_back(make_request(CMD_QUERY, 63, 0));
		command_queue.push_back(make_request(CMD_CONNECT, 62, 63));
		command_queue.push_back(make_request(CMD_CONNECT, 5, 3));
		command_queue.push_back(make_request(CMD_CONNECT, 7, 7));
		command_queue.push_back(make_request(CMD_QUERY, 9, 9));
		command_queue.push_back(make_request(CMD_DISCONNECT, 4, 4));
		command_queue.push_back(make_request(CMD_NEXT, 63, 63));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		// A link behind the cursor stays hidden until the next restart.
		command_queue.push_back(make_request(CMD_CONNECT, 1, 2));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		command_queue.push_back(make_request(CMD_RESTART, 63, 63));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		command_queue.push_back(make_request(CMD_DISCONNECT, 0, 63));
		command_queue.push_back(make_request(CMD_DISCONNECT, 63, 0));
		command_queue.push_back(make_request(CMD_QUERY, 0, 63));
		command_queue.push_back(make_request(CMD_SPARE_LO, 1, 2));
		command_queue.push_back(make_request(CMD_SPARE_MID, 63, 63));
		command_queue.push_back(make_request(CMD_SPARE_HI, 63, 0));
		command_queue.push_back(make_request(CMD_RESTART, 0, 0));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		queue_random_commands(140);
		wait_until_drained();

		// Two vertices: the range check is made before the self-loop check.
		write_vertex_count(7'd2);
		command_queue.push_back(make_request(CMD_CONNECT, 0, 1));
		command_queue.push_back(make_request(CMD_CONNECT, 1, 2));
		command_queue.push_back(make_request(CMD_QUERY, 2, 2));
		command_queue.push_back(make_request(CMD_QUERY, 1, 1));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		command_queue.push_back(make_request(CMD_NEXT, 0, 0));
		command_queue.push_back(make_request(CMD_DISCONNECT, 1, 0));
		queue_random_commands(40);
		wait_until_drained();

		// No usable vertex, then a single one: no pair can be connected.
		write_vertex_count(7'd0);
		queue_random_commands(20);
		wait_until_drained();
		write_vertex_count(7'd1);
		queue_random_commands(20);
		wait_until_drained();

		// Above the cap the block uses the full vertex range.
		write_vertex_count(7'd127);
		queue_random_commands(150);
		wait_until_drained();

		write_vertex_count(7'd5);
		queue_random_commands(80);
		wait_until_drained();

		write_vertex_count(VCOUNT_W'($urandom_range(VERTEX_LIMIT - 1, 3)));
		queue_random_commands(150);
		wait_until_drained();

		// The last part runs back to back, with no idle cycles from the sender.
		write_vertex_count(7'd64);
		pauses_allowed = 1'b0;
		queue_random_commands(180);
		wait_until_drained();

		// Give the block time to show any result it should not produce.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_answers.size() != 0) begin
			$error("%0d answers never arrived", awaited_answers.size());
			failures++;
		end
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
